// ----- src/slt_pkg.sv -----
// Shared types, character codes and escape helpers for the line trace ring.
// Used by the front, the back and the top level.
`default_nettype none

package slt_pkg;

  // Default geometry of the ring.
  localparam int unsigned SLOT_COUNT_DEF = 128;
  localparam int unsigned LINE_WIDTH_DEF = 160;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Width of a stored line length and of a pending byte count.
  localparam int unsigned LEN_W = 8;

  // Character codes.
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_R   = 8'h72;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_U   = 8'h75;

  // Request codes.
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_LOCATE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // One input beat.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  byte_in;
    logic [31:0] line_seq;
    logic [7:0]  line_budget;
    logic [7:0]  char_offset;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] start_seq;
    logic [31:0] end_seq;
    logic [31:0] newest_seq;
    logic [7:0]  line_length;
    logic        line_valid;
  } result_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    mode_e       kind;
    logic [31:0] newest;
    logic [31:0] start;
    logic [7:0]  take;
    logic [7:0]  offset;
    logic        held;
  } desc_t;

  // Lowercase hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CH_ZERO + {4'b0000, v};
    end else begin
      r = CH_LOW_A + {4'b0000, v} - 8'd10;
    end
    return r;
  endfunction

  // Number of bytes in the escaped form of a character.
  function automatic logic [2:0] esc_count(input logic [7:0] c);
    logic [2:0] n;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_LF, CH_TAB, CH_CR: n = 3'd2;
      default: begin
        if (c < CTRL_LIMIT) begin
          n = 3'd6;
        end else begin
          n = 3'd1;
        end
      end
    endcase
    return n;
  endfunction

  // Byte k of the escaped form of a character.
  function automatic logic [7:0] esc_byte(input logic [7:0] c, input logic [2:0] k);
    logic [7:0] r;
    r = c;
    case (c)
      CH_QUOTE:  r = (k == 3'd0) ? CH_BSLASH : CH_QUOTE;
      CH_BSLASH: r = CH_BSLASH;
      CH_LF:     r = (k == 3'd0) ? CH_BSLASH : CH_LOW_N;
      CH_TAB:    r = (k == 3'd0) ? CH_BSLASH : CH_LOW_T;
      CH_CR:     r = (k == 3'd0) ? CH_BSLASH : CH_LOW_R;
      default: begin
        if (c < CTRL_LIMIT) begin
          case (k)
            3'd0:    r = CH_BSLASH;
            3'd1:    r = CH_LOW_U;
            3'd2:    r = CH_ZERO;
            3'd3:    r = CH_ZERO;
            3'd4:    r = hex_digit(c[7:4]);
            default: r = hex_digit(c[3:0]);
          endcase
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/slt_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat per handshake.
// The payload type is chosen per instance.
`default_nettype none

interface slt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/slt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module slt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/slt_fifo.sv -----
// Short first-in first-out queue between the front and the back.
// No dependencies.
`default_nettype none

module slt_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q;
  logic [PW-1:0]    rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/slt_front.sv -----
// Front of the trace ring: accepts beats, builds and commits lines, keeps the
// sequence window and classifies locate and read requests. Uses slt_pkg.
`default_nettype none

module slt_front #(
  parameter int unsigned SLOT_COUNT = slt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned LINE_WIDTH = slt_pkg::LINE_WIDTH_DEF,
  localparam int unsigned ROWS = 2 * SLOT_COUNT,
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned TW = $clog2(ROWS * LINE_WIDTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  slt_pkg::item_t               item_i,
  input  logic                         full_i,
  output logic                         push_o,
  output slt_pkg::desc_t               push_desc_o,
  output logic [RW-1:0]                push_row_o,
  output logic                         text_we_o,
  output logic [TW-1:0]                text_waddr_o,
  output logic [7:0]                   text_wdata_o,
  output logic                         len_we_o,
  output logic [RW-1:0]                len_waddr_o,
  output logic [slt_pkg::LEN_W-1:0]    len_wdata_o
);
  import slt_pkg::*;

  logic [31:0]      next_q, next_d;
  logic [31:0]      oldest_q, oldest_d;
  logic [RW-1:0]    row_q, row_d;
  logic [TW-1:0]    base_q, base_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] cnt_inc;

  logic accept, is_append, is_lf, is_cr, store, full_hit, commit;
  logic seq_wrap, row_last;

  logic        below, above, held;
  logic [31:0] win, span, avail, start;
  logic [7:0]  take;
  logic [RW-1:0] k;
  logic [RW:0]   rdiff, rwrap;

  // Handshake: a beat enters whenever the queue has room.
  assign item_ready_o = !full_i;
  assign accept       = item_valid_i && !full_i;
  assign push_o       = accept;

  // Append decoding.
  assign is_append = accept && (mode_e'(item_i.mode) == MODE_APPEND);
  assign is_lf     = (item_i.byte_in == CH_LF);
  assign is_cr     = (item_i.byte_in == CH_CR);
  assign store     = is_append && !is_lf && !is_cr;
  assign cnt_inc   = cnt_q + LEN_W'(1);
  assign full_hit  = store && (cnt_inc == LEN_W'(LINE_WIDTH));
  assign commit    = (is_append && is_lf && (cnt_q != '0)) || full_hit;

  // Pending bytes go straight into the row that the next line will own.
  assign text_we_o    = store;
  assign text_waddr_o = base_q + TW'(cnt_q);
  assign text_wdata_o = item_i.byte_in;

  // A commit records the line length for the pending row.
  assign len_we_o    = commit;
  assign len_waddr_o = row_q;
  assign len_wdata_o = full_hit ? cnt_inc : cnt_q;

  assign seq_wrap = (next_q == '1);
  assign row_last = (row_q == RW'(ROWS - 1));

  // Next state of the line builder and the sequence window.
  always_comb begin
    next_d   = next_q;
    oldest_d = oldest_q;
    row_d    = row_q;
    base_d   = base_q;
    cnt_d    = cnt_q;
    if (store) begin
      cnt_d = cnt_inc;
    end
    if (commit) begin
      cnt_d = '0;
      if (seq_wrap) begin
        // The window restarts at zero after the sequence wraps.
        next_d   = '0;
        oldest_d = '0;
        row_d    = '0;
        base_d   = '0;
      end else begin
        next_d   = next_q + 32'd1;
        oldest_d = (next_q >= 32'(SLOT_COUNT)) ? oldest_q + 32'd1 : oldest_q;
        row_d    = row_last ? '0 : row_q + RW'(1);
        base_d   = row_last ? '0 : base_q + TW'(LINE_WIDTH);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q   <= '0;
      oldest_q <= '0;
      row_q    <= '0;
      base_q   <= '0;
      cnt_q    <= '0;
    end else begin
      next_q   <= next_d;
      oldest_q <= oldest_d;
      row_q    <= row_d;
      base_q   <= base_d;
      cnt_q    <= cnt_d;
    end
  end

  // Window position of the requested sequence.
  assign below = (item_i.line_seq < oldest_q);
  assign above = (item_i.line_seq > next_q);
  assign held  = !below && (item_i.line_seq < next_q);
  assign win   = next_q - oldest_q;
  assign span  = next_q - item_i.line_seq;

  // Locate: clamp to the window and limit the line count.
  always_comb begin
    if (below) begin
      start = oldest_q;
      avail = win;
    end else if (above) begin
      start = next_q;
      avail = '0;
    end else begin
      start = item_i.line_seq;
      avail = span;
    end
    if ((avail[31:8] != '0) || (avail[7:0] >= item_i.line_budget)) begin
      take = item_i.line_budget;
    end else begin
      take = avail[7:0];
    end
  end

  // Read: a held line sits k rows behind the pending row, modulo the row count.
  assign k          = next_q[RW-1:0] - item_i.line_seq[RW-1:0];
  assign rdiff      = {1'b0, row_q} - {1'b0, k};
  assign rwrap      = rdiff + (RW + 1)'(ROWS);
  assign push_row_o = rdiff[RW] ? rwrap[RW-1:0] : rdiff[RW-1:0];

  // Classified request for the back.
  always_comb begin
    push_desc_o.kind   = mode_e'(item_i.mode);
    push_desc_o.newest = next_d;
    push_desc_o.start  = start;
    push_desc_o.take   = take;
    push_desc_o.offset = item_i.char_offset;
    push_desc_o.held   = held;
  end

endmodule

`default_nettype wire

// ----- src/slt_back.sv -----
// Back of the trace ring: reads the ring for each queued request, escapes the
// character and emits result beats through an output register. Uses slt_pkg.
`default_nettype none

module slt_back #(
  parameter int unsigned SLOT_COUNT = slt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned LINE_WIDTH = slt_pkg::LINE_WIDTH_DEF,
  localparam int unsigned ROWS = 2 * SLOT_COUNT,
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned TW = $clog2(ROWS * LINE_WIDTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  slt_pkg::desc_t            desc_i,
  input  logic [RW-1:0]             row_i,
  output logic                      text_re_o,
  output logic [TW-1:0]             text_raddr_o,
  input  logic [7:0]                text_rdata_i,
  output logic                      len_re_o,
  output logic [RW-1:0]             len_raddr_o,
  input  logic [slt_pkg::LEN_W-1:0] len_rdata_i,
  output logic                      result_valid_o,
  input  logic                      result_ready_i,
  output slt_pkg::result_t          result_o
);
  import slt_pkg::*;

  desc_t      e_q;
  logic       e_valid_q;
  logic [2:0] idx_q;
  logic       out_valid_q;
  result_t    out_q;

  result_t    cur;
  logic       out_free, step, e_done, pop;
  logic [2:0] n;
  logic       hit;
  logic [LEN_W-1:0] line_len;

  // Pipeline control: a request leaves the stage with its final beat.
  assign out_free = !out_valid_q || result_ready_i;
  assign step     = e_valid_q && out_free;
  assign e_done   = step && cur.last;
  assign pop      = !q_empty_i && (!e_valid_q || e_done);

  assign q_pop_o  = pop;

  // Ring reads are issued as a request is taken from the queue.
  assign text_re_o    = pop;
  assign text_raddr_o = TW'(row_i) * TW'(LINE_WIDTH) + TW'(desc_i.offset);
  assign len_re_o     = pop;
  assign len_raddr_o  = row_i;

  // Character checks on the read data.
  assign n        = esc_count(text_rdata_i);
  assign hit      = e_q.held && (e_q.offset < len_rdata_i);
  assign line_len = e_q.held ? len_rdata_i : '0;

  // Current result beat.
  always_comb begin
    cur            = '0;
    cur.newest_seq = e_q.newest;
    cur.last       = 1'b1;
    case (e_q.kind)
      MODE_LOCATE: begin
        cur.start_seq = e_q.start;
        cur.end_seq   = e_q.start + 32'(e_q.take);
      end
      MODE_READ: begin
        cur.line_length = line_len;
        if (hit) begin
          cur.out_byte   = esc_byte(text_rdata_i, idx_q);
          cur.line_valid = 1'b1;
          cur.last       = (idx_q == n - 3'd1);
        end
      end
      default: begin
      end
    endcase
  end

  // Stage and output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        e_valid_q <= 1'b1;
        idx_q     <= '0;
      end else if (e_done) begin
        e_valid_q <= 1'b0;
      end else if (step) begin
        idx_q <= idx_q + 3'd1;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      e_q <= desc_i;
    end
    if (step) begin
      out_q <= cur;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire

// ----- src/sequenced_line_trace_ring_core.sv -----
// Sequenced line trace ring: log bytes are collected into numbered lines that
// are kept in a ring and read back as escaped characters.
//
// Channels: item_i takes one request beat (append byte, locate window, read
// character, or a no-op code); result_o gives the result beats, one per beat,
// with last marking the final beat of a request. A read of an escaped
// character gives 1 to 6 beats, every other request exactly one.
// Path: an accepted request passes the queue, the back stage with its
// registered ring read and the output register, in that order.
// Throughput: while result_o.ready stays high, one request per cycle for
// appends, locates and no-ops; a read occupies the back for its escaped
// bytes, emitted one byte per cycle from the registered ring read.
// The front takes a new beat whenever the two-entry queue has room, so a
// stalled receiver first fills the output register, the back stage and the
// queue before item_i.ready drops; nothing is lost or repeated.
// Reset empties the pending line and the window; the ring memory is not
// cleared and needs no clearing pass, since only held lines are read.
`default_nettype none

module sequenced_line_trace_ring_core #(
  parameter int unsigned SLOT_COUNT = slt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned LINE_WIDTH = slt_pkg::LINE_WIDTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  slt_stream_if.sink   item_i,
  slt_stream_if.source result_o
);
  import slt_pkg::*;

  localparam int unsigned ROWS       = 2 * SLOT_COUNT;
  localparam int unsigned RW         = $clog2(ROWS);
  localparam int unsigned TEXT_DEPTH = ROWS * LINE_WIDTH;
  localparam int unsigned TW         = $clog2(TEXT_DEPTH);
  localparam int unsigned QW         = $bits(desc_t) + RW;

  logic             q_full, q_empty, q_push, q_pop;
  desc_t            push_desc, pop_desc;
  logic [RW-1:0]    push_row, pop_row;
  logic [QW-1:0]    q_wdata, q_rdata;

  logic             text_we, text_re;
  logic [TW-1:0]    text_waddr, text_raddr;
  logic [7:0]       text_wdata, text_rdata;
  logic             len_we, len_re;
  logic [RW-1:0]    len_waddr, len_raddr;
  logic [LEN_W-1:0] len_wdata, len_rdata;

  // Front: line building and request classification.
  slt_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .item_i       (item_i.data),
    .full_i       (q_full),
    .push_o       (q_push),
    .push_desc_o  (push_desc),
    .push_row_o   (push_row),
    .text_we_o    (text_we),
    .text_waddr_o (text_waddr),
    .text_wdata_o (text_wdata),
    .len_we_o     (len_we),
    .len_waddr_o  (len_waddr),
    .len_wdata_o  (len_wdata)
  );

  // Queue between front and back.
  assign q_wdata = {push_desc, push_row};
  assign {pop_desc, pop_row} = q_rdata;

  slt_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Line text, two rows per logical slot so the pending line never
  // overwrites a held one.
  slt_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (text_waddr),
    .wdata_i (text_wdata),
    .re_i    (text_re),
    .raddr_i (text_raddr),
    .rdata_o (text_rdata)
  );

  // Stored line lengths, one per row.
  slt_ram #(
    .WIDTH (LEN_W),
    .DEPTH (ROWS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  // Back: ring reads, escaping and result output.
  slt_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .desc_i         (pop_desc),
    .row_i          (pop_row),
    .text_re_o      (text_re),
    .text_raddr_o   (text_raddr),
    .text_rdata_i   (text_rdata),
    .len_re_o       (len_re),
    .len_raddr_o    (len_raddr),
    .len_rdata_i    (len_rdata),
    .result_valid_o (result_o.valid),
    .result_ready_i (result_o.ready),
    .result_o       (result_o.data)
  );

endmodule

`default_nettype wire
